// ----- rtl/rmmt_pkg.sv -----
// Package for the range max/min tree: sizes, value limits, command codes,
// node and memory-port types, and the signed max/min helpers.
// No dependencies.
`default_nettype none
package rmmt_pkg;

   localparam int LEAF_COUNT = 1024;
   localparam int LEAF_BITS  = $clog2(LEAF_COUNT);
   localparam int NODE_COUNT = 2 * LEAF_COUNT;
   localparam int ADDR_BITS  = LEAF_BITS + 1;
   // walk indices must hold NODE_COUNT itself
   localparam int WALK_BITS  = ADDR_BITS + 1;
   localparam int VALUE_BITS = 32;
   localparam int POS_BITS   = 10;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [POS_BITS-1:0]          pos_type;
   typedef logic [ADDR_BITS-1:0]         addr_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      value_type hi;   // node maximum
      value_type lo;   // node minimum
   } node_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      node_type data;
   } mem_wr_type;

   typedef struct packed {
      logic      valid;
      value_type range_max;
      value_type range_min;
      logic      empty;
   } result_type;

   function automatic value_type max_of(input value_type a, input value_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic value_type min_of(input value_type a, input value_type b);
      return (b < a) ? b : a;
   endfunction

   function automatic node_type merge(input node_type a, input node_type b);
      node_type m;
      m.hi = max_of(a.hi, b.hi);
      m.lo = min_of(a.lo, b.lo);
      return m;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/rmmt_node_store.sv -----
// Node memory of the tree: one write port, two registered read ports.
// Depends on rmmt_pkg.
`default_nettype none
module rmmt_node_store
   import rmmt_pkg::*;
(
   input  wire        clock,
   input  mem_wr_type wr,
   input  addr_type   rd_a_addr,
   input  addr_type   rd_b_addr,
   output node_type   rd_a_data,
   output node_type   rd_b_data
);

   node_type mem [NODE_COUNT];
   node_type rd_a_ff;
   node_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
`default_nettype wire

// ----- rtl/rmmt_seq.sv -----
// Sequencer: clearing sweep, leaf-to-root update walk, bottom-up range query walk.
// Depends on rmmt_pkg; drives rmmt_node_store.
`default_nettype none
module rmmt_seq
   import rmmt_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire        req_command,
   input  pos_type    req_position,
   input  value_type  req_new_value,
   input  pos_type    req_range_low,
   input  pos_type    req_range_high,
   input  pos_type    active_len,
   output mem_wr_type wr,
   output addr_type   rd_a_addr,
   output addr_type   rd_b_addr,
   input  node_type   rd_a_data,
   input  node_type   rd_b_data,
   output result_type res
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_UPD   = 5'b00100,
      ST_QRY   = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [WALK_BITS-1:0]   clr_ff, clr_in;
   addr_type               k_ff, k_in;
   node_type               cur_ff, cur_in;
   logic [WALK_BITS-1:0]   l_ff, l_in, r_ff, r_in;
   node_type               acc_ff, acc_in;
   logic                   pend_a_ff, pend_a_in, pend_b_ff, pend_b_in;

   pos_type                top_pos, lo_c, hi_c;
   logic                   q_empty;
   node_type               acc_m, upd_node;
   addr_type               leaf, parent;
   logic [WALK_BITS-1:0]   l_nx, r_nx, r_dec;

   always_comb begin
      top_pos = (32'(active_len) > 32'(LEAF_COUNT - 1)) ? POS_BITS'(LEAF_COUNT - 1)
                                                         : active_len;
      lo_c    = (req_range_low == '0) ? POS_BITS'(1) : req_range_low;
      hi_c    = (req_range_high > top_pos) ? top_pos : req_range_high;
      q_empty = lo_c > hi_c;

      acc_m = acc_ff;
      if (pend_a_ff) acc_m = merge(acc_m, rd_a_data);
      if (pend_b_ff) acc_m = merge(acc_m, rd_b_data);

      leaf     = ADDR_BITS'(LEAF_COUNT) + ADDR_BITS'(req_position);
      parent   = k_ff >> 1;
      upd_node = merge(cur_ff, rd_a_data);
      l_nx     = (l_ff + WALK_BITS'(l_ff[0])) >> 1;
      r_nx     = r_ff >> 1;
      r_dec    = r_ff - WALK_BITS'(1);

      state_in  = state_ff;
      clr_in    = clr_ff;
      k_in      = k_ff;
      cur_in    = cur_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      acc_in    = acc_ff;
      pend_a_in = 1'b0;
      pend_b_in = 1'b0;
      wr        = '0;
      rd_a_addr = '0;
      rd_b_addr = '0;
      res       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = clr_ff[ADDR_BITS-1:0];
            clr_in  = clr_ff + WALK_BITS'(1);
            if (clr_ff == WALK_BITS'(NODE_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_UPDATE) begin
                  if (req_position != '0 && req_position <= top_pos) begin
                     wr.en      = 1'b1;
                     wr.addr    = leaf;
                     wr.data    = '{hi: req_new_value, lo: req_new_value};
                     rd_a_addr  = leaf ^ ADDR_BITS'(1);
                     k_in       = leaf;
                     cur_in     = '{hi: req_new_value, lo: req_new_value};
                     state_in   = ST_UPD;
                  end
               end else if (q_empty) begin
                  res.valid     = 1'b1;
                  res.range_max = VALUE_MIN;
                  res.range_min = VALUE_MAX;
                  res.empty     = 1'b1;
               end else begin
                  l_in     = WALK_BITS'(LEAF_COUNT) + WALK_BITS'(lo_c);
                  r_in     = WALK_BITS'(LEAF_COUNT) + WALK_BITS'(hi_c) + WALK_BITS'(1);
                  acc_in   = '{hi: VALUE_MIN, lo: VALUE_MAX};
                  state_in = ST_QRY;
               end
            end
         end
         ST_UPD: begin
            // sibling arrived; path value is held in cur_ff
            wr.en   = 1'b1;
            wr.addr = parent;
            wr.data = upd_node;
            cur_in  = upd_node;
            k_in    = parent;
            if (parent == ADDR_BITS'(1)) state_in = ST_IDLE;
            else rd_a_addr = parent ^ ADDR_BITS'(1);
         end
         ST_QRY: begin
            acc_in    = acc_m;
            rd_a_addr = l_ff[ADDR_BITS-1:0];
            rd_b_addr = r_dec[ADDR_BITS-1:0];
            pend_a_in = l_ff[0];
            pend_b_in = r_ff[0];
            l_in      = l_nx;
            r_in      = r_nx;
            if (!(l_nx < r_nx)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            res.valid     = 1'b1;
            res.range_max = acc_m.hi;
            res.range_min = acc_m.lo;
            res.empty     = 1'b0;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase

      busy = state_ff != ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pend_a_ff <= pend_a_in;
         pend_b_ff <= pend_b_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      cur_ff <= cur_in;
      l_ff   <= l_in;
      r_ff   <= r_in;
      acc_ff <= acc_in;
   end

endmodule
`default_nettype wire

// ----- rtl/range_max_min_tree_top.sv -----
// Top level of the range max/min tree: config register, result register,
// sequencer and node memory. Depends on rmmt_pkg, rmmt_seq, rmmt_node_store.
`default_nettype none
// Range max/min over positions 1..active_length of a table of signed 32-bit
// values, held as a heap-ordered tree (node 1 is the root, leaves at
// LEAF_COUNT+position), each node storing max and min of its subtree in one
// memory word. After reset the block is busy while it sweeps all NODE_COUNT =
// 2048 node memory entries to zero, one entry a cycle; csr writes are taken
// during that time. A request is taken when start is high and busy is low.
// An update walks from the leaf to the root: first it writes the leaf and
// reads its sibling, then at each tree level it merges the path value with
// the sibling from the registered memory read port and writes the parent.
// An ignored update (position 0 or above active_length) leaves the block
// idle. A query walks both range edges upward together using the memory's
// two read ports, one level a cycle (at most 10 levels, since position 0 is
// never in range), between setup in idle and a drain state, the result
// showing in the cycle after the drain. An empty query answers the cycle
// after it is taken. The result appears on rsp_* for exactly one cycle, flagged
// by rsp_valid; the receiver cannot stall it, and a new request may be taken
// in that same cycle. Updates give no result. active_length must be written
// through csr_wr_en/csr_wr_data only while idle; the block does not enforce it.
module range_max_min_tree_top
   import rmmt_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  wire               req_command,
   input  wire  pos_type     req_position,
   input  wire  value_type   req_new_value,
   input  wire  pos_type     req_range_low,
   input  wire  pos_type     req_range_high,
   input  wire               csr_wr_en,
   input  wire  pos_type     csr_wr_data,
   output logic              rsp_valid,
   output value_type         rsp_range_max,
   output value_type         rsp_range_min,
   output logic              rsp_empty_range
);

   // active_length register
   pos_type    active_len_ff;

   // memory ports between sequencer and node store
   mem_wr_type wr;
   addr_type   rd_a_addr, rd_b_addr;
   node_type   rd_a_data, rd_b_data;

   // result from the sequencer, registered onto the rsp ports
   result_type res;
   logic       rsp_valid_ff;
   value_type  rsp_max_ff, rsp_min_ff;
   logic       rsp_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_len_ff <= '0;
      end else if (csr_wr_en) begin
         active_len_ff <= csr_wr_data;
      end
   end

   rmmt_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .active_len     (active_len_ff),
      .wr             (wr),
      .rd_a_addr      (rd_a_addr),
      .rd_b_addr      (rd_b_addr),
      .rd_a_data      (rd_a_data),
      .rd_b_data      (rd_b_data),
      .res            (res)
   );

   rmmt_node_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // strobe is a one-cycle pulse; payload just follows
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         rsp_max_ff   <= res.range_max;
         rsp_min_ff   <= res.range_min;
         rsp_empty_ff <= res.empty;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_max   = rsp_max_ff;
   assign rsp_range_min   = rsp_min_ff;
   assign rsp_empty_range = rsp_empty_ff;

endmodule
`default_nettype wire

// ----- rtl/rmmt_checker.sv -----
// Port-level checks for range_max_min_tree_top, attached by bind.
// Depends on rmmt_pkg.
`default_nettype none
module rmmt_checker
   import rmmt_pkg::*;
(
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input wire               req_command,
   input wire               rsp_valid,
   input wire value_type    rsp_range_max,
   input wire value_type    rsp_range_min,
   input wire               rsp_empty_range
);

   // memory sweep follows every reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // updates never produce a result
   a_update_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_UPDATE) |=> !rsp_valid)
      else $error("result after update");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_range) |->
         (rsp_range_max == VALUE_MIN && rsp_range_min == VALUE_MAX))
      else $error("empty result values wrong");

   a_max_ge_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_range) |-> (rsp_range_max >= rsp_range_min))
      else $error("max below min");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while result shown");

endmodule

bind range_max_min_tree_top rmmt_checker u_rmmt_checker (.*);
`default_nettype wire

// ----- sim/range_max_min_tree_top_tb.sv -----
// Testbench for range_max_min_tree_top: a directed table followed by random
// update/query phases at several active lengths, checked against a local tree.
// Depends on rmmt_pkg and the RTL of range_max_min_tree_top.
`default_nettype none
module range_max_min_tree_top_tb;
   import rmmt_pkg::*;

   // One request as presented on the req_* ports
   typedef struct packed {
      logic      command;
      pos_type   position;
      value_type new_value;
      pos_type   range_low;
      pos_type   range_high;
   } request_type;

   // One query answer as seen on the rsp_* ports
   typedef struct packed {
      value_type mx;
      value_type mn;
      logic      empty;
   } range_answer_type;

   typedef enum logic {ROW_CFG, ROW_REQ} row_kind_type;

   // Directed table row: a length write, or a request with an optional
   // hand-written answer (otherwise the local tree supplies it)
   typedef struct packed {
      row_kind_type     kind;
      pos_type          length;
      request_type      req;
      logic             typed;
      range_answer_type answer;
   } plan_row_type;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 144;
   localparam int QUIET_PHASE  = 4;    // phase run with no sender gaps
   localparam int SETTLE_WAIT  = 16;   // covers an update still walking up
   localparam int DRAIN_WAIT   = 20;
   localparam int MAX_REPORTS  = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_command = CMD_UPDATE;
   logic [9:0]        req_position = '0;
   logic signed [31:0] req_new_value = '0;
   logic [9:0]        req_range_low = '0;
   logic [9:0]        req_range_high = '0;
   logic              csr_wr_en = 1'b0;
   logic [9:0]        csr_wr_data = '0;
   logic              rsp_valid;
   logic signed [31:0] rsp_range_max;
   logic signed [31:0] rsp_range_min;
   logic              rsp_empty_range;

   // Local copy of the tree: heap layout, node 1 is the root, leaf p at
   // LEAF_COUNT + p. Cleared to zero like the block after reset.
   value_type     tree_hi [0:NODE_COUNT-1];
   value_type     tree_lo [0:NODE_COUNT-1];
   pos_type       active_len = '0;

   range_answer_type pending_answers [$];
   plan_row_type     plan [$];
   int               fail_count = 0;
   logic             sender_idles = 1'b1;

   range_max_min_tree_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_range_max   (rsp_range_max),
      .rsp_range_min   (rsp_range_min),
      .rsp_empty_range (rsp_empty_range)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic value_type bigger_of(input value_type a, input value_type b);
      return ($signed(a) < $signed(b)) ? b : a;
   endfunction

   function automatic value_type smaller_of(input value_type a, input value_type b);
      return ($signed(b) < $signed(a)) ? b : a;
   endfunction

   // Point update: ignored at position 0 or past the active length
   function automatic void write_leaf(input pos_type p, input value_type v);
      int k;
      if (p == 0 || p > active_len) return;
      k = LEAF_COUNT + p;
      tree_hi[k] = v;
      tree_lo[k] = v;
      while (k > 1) begin
         k = k / 2;
         tree_hi[k] = bigger_of(tree_hi[2*k], tree_hi[2*k+1]);
         tree_lo[k] = smaller_of(tree_lo[2*k], tree_lo[2*k+1]);
      end
   endfunction

   // Range query: low raised to 1, high lowered to the active length;
   // an empty clipped range answers with the inverted extremes
   function automatic range_answer_type range_answer(input pos_type lo_in,
                                                     input pos_type hi_in);
      range_answer_type a;
      int lo, hi, l, r;
      a.mx = VALUE_MIN;
      a.mn = VALUE_MAX;
      a.empty = 1'b1;
      lo = (lo_in < 1) ? 1 : int'(lo_in);
      hi = (hi_in > active_len) ? int'(active_len) : int'(hi_in);
      if (lo <= hi) begin
         a.empty = 1'b0;
         l = lo + LEAF_COUNT;
         r = hi + LEAF_COUNT + 1;
         while (l < r) begin
            if (l % 2 == 1) begin
               a.mx = bigger_of(a.mx, tree_hi[l]);
               a.mn = smaller_of(a.mn, tree_lo[l]);
               l = l + 1;
            end
            if (r % 2 == 1) begin
               r = r - 1;
               a.mx = bigger_of(a.mx, tree_hi[r]);
               a.mn = smaller_of(a.mn, tree_lo[r]);
            end
            l = l / 2;
            r = r / 2;
         end
      end
      return a;
   endfunction

   // Table builders
   function automatic plan_row_type cfg_row(input pos_type len);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CFG;
      row.length = len;
      return row;
   endfunction

   function automatic plan_row_type upd(input pos_type p, input value_type v);
      plan_row_type row;
      row = '0;
      row.kind = ROW_REQ;
      row.req.command = CMD_UPDATE;
      row.req.position = p;
      row.req.new_value = v;
      return row;
   endfunction

   function automatic plan_row_type qry(input pos_type lo, input pos_type hi);
      plan_row_type row;
      row = '0;
      row.kind = ROW_REQ;
      row.req.command = CMD_QUERY;
      row.req.range_low = lo;
      row.req.range_high = hi;
      return row;
   endfunction

   function automatic plan_row_type qry_is(input pos_type lo, input pos_type hi,
                                           input value_type mx, input value_type mn,
                                           input logic e);
      plan_row_type row;
      row = qry(lo, hi);
      row.typed = 1'b1;
      row.answer.mx = mx;
      row.answer.mn = mn;
      row.answer.empty = e;
      return row;
   endfunction

   // Values: extremes, a narrow band near zero (many ties), full random
   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2, 3:    return value_type'(int'($urandom_range(0, 200)) - 100);
         default: return value_type'($urandom);
      endcase
   endfunction

   // Random request, mostly aimed at the active positions
   function automatic request_type random_request(input pos_type len);
      request_type r;
      int a, b;
      r.command = ($urandom_range(0, 99) < 55) ? CMD_UPDATE : CMD_QUERY;
      r.new_value = pick_value();
      r.position = pos_type'($urandom);
      r.range_low = pos_type'($urandom);
      r.range_high = pos_type'($urandom);
      if (r.command == CMD_UPDATE) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: r.position = (len > 0) ? pos_type'($urandom_range(1, len)) : '0;
            7: r.position = '0;
            8: r.position = (len < 1023) ? pos_type'($urandom_range(len + 1, 1023))
                                         : pos_type'($urandom);
            default: ;
         endcase
      end else begin
         a = $urandom_range(0, len + 1 > 1023 ? 1023 : len + 1);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               b = $urandom_range(0, len + 1 > 1023 ? 1023 : len + 1);
               r.range_low = pos_type'((a < b) ? a : b);
               r.range_high = pos_type'((a < b) ? b : a);
            end
            3, 4, 5: begin
               // narrow window
               b = a + $urandom_range(0, 8);
               r.range_low = pos_type'(a);
               r.range_high = pos_type'((b > 1023) ? 1023 : b);
            end
            6: begin
               // reversed bounds
               b = $urandom_range(0, 1023);
               r.range_low = pos_type'((a > b) ? a : b);
               r.range_high = pos_type'((a > b) ? b : a);
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // Present one request from a falling edge, hold it until taken, then
   // predict from the pre-edge state. Returns at the following falling edge.
   task automatic issue(input request_type r, input logic typed,
                        input range_answer_type fixed);
      range_answer_type predicted;
      while (sender_idles && $urandom_range(0, 99) < 37) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_command    <= r.command;
      req_position   <= r.position;
      req_new_value  <= r.new_value;
      req_range_low  <= r.range_low;
      req_range_high <= r.range_high;
      do @(posedge clock); while (busy !== 1'b0);
      if (r.command == CMD_QUERY) begin
         predicted = range_answer(r.range_low, r.range_high);
         pending_answers.push_back(typed ? fixed : predicted);
      end else begin
         write_leaf(r.position, r.new_value);
      end
      @(negedge clock);
   endtask

   // Change the active length once the block has gone quiet.
   // Called at a falling edge, returns at one.
   task automatic set_length(input pos_type len);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      // an update gives no result, so it may still be walking the tree
      repeat (SETTLE_WAIT) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      active_len = len;
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endtask

   // Result checker: every strobed result must match the oldest query
   always @(posedge clock) begin
      range_answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_answers.size() == 0) begin
            note_failure($sformatf("unexpected result max=%0d min=%0d empty=%b",
                                   rsp_range_max, rsp_range_min, rsp_empty_range));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_range_max !== want.mx || rsp_range_min !== want.mn ||
                rsp_empty_range !== want.empty)
               note_failure($sformatf(
                  "expected max=%0d min=%0d empty=%b, got max=%0d min=%0d empty=%b",
                  $signed(want.mx), $signed(want.mn), want.empty,
                  rsp_range_max, rsp_range_min, rsp_empty_range));
         end
      end
   end

   initial begin
      pos_type     phase_len [PHASES];
      request_type r;
      for (int i = 0; i < NODE_COUNT; i++) begin
         tree_hi[i] = '0;
         tree_lo[i] = '0;
      end

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed table. After reset the active length is 0, so every
      // query is empty and every update is dropped.
      plan.push_back(qry_is(0, 1023, VALUE_MIN, VALUE_MAX, 1'b1));
      plan.push_back(upd(1, 5));
      plan.push_back(qry_is(1, 1, VALUE_MIN, VALUE_MAX, 1'b1));
      plan.push_back(cfg_row(1023));
      // untouched tree reads back zero
      plan.push_back(qry_is(1, 1023, 0, 0, 1'b0));
      plan.push_back(upd(1, VALUE_MIN));
      plan.push_back(upd(1023, VALUE_MAX));
      plan.push_back(upd(0, 77));                 // position 0 is never stored
      plan.push_back(upd(512, -1));
      plan.push_back(qry_is(0, 1023, VALUE_MAX, VALUE_MIN, 1'b0));
      plan.push_back(qry_is(1023, 1023, VALUE_MAX, VALUE_MAX, 1'b0));
      plan.push_back(qry_is(1, 1, VALUE_MIN, VALUE_MIN, 1'b0));
      plan.push_back(qry_is(5, 3, VALUE_MIN, VALUE_MAX, 1'b1));   // reversed
      plan.push_back(qry_is(0, 0, VALUE_MIN, VALUE_MAX, 1'b1));   // low raised past high
      plan.push_back(qry(2, 1022));
      plan.push_back(cfg_row(0));
      plan.push_back(qry_is(1, 1023, VALUE_MIN, VALUE_MAX, 1'b1));
      plan.push_back(upd(1, 9));                  // dropped, length is 0
      // leaves keep their values across length changes
      plan.push_back(cfg_row(600));
      plan.push_back(qry(1, 1023));
      plan.push_back(upd(700, 3));                // past the active length
      plan.push_back(qry(600, 1023));
      plan.push_back(qry(513, 599));

      @(negedge clock);
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG)
            set_length(plan[i].length);
         else
            issue(plan[i].req, plan[i].typed, plan[i].answer);
      end

      // Random phases: length extremes, tiny trees and random lengths
      phase_len[0] = 1023;
      phase_len[1] = 1;
      phase_len[2] = 0;
      phase_len[3] = pos_type'($urandom_range(2, 16));
      phase_len[4] = pos_type'($urandom_range(1, 1023));
      phase_len[5] = pos_type'($urandom_range(1, 1023));
      phase_len[6] = pos_type'($urandom_range(1, 1023));
      phase_len[7] = 1023;
      for (int p = 0; p < PHASES; p++) begin
         set_length(phase_len[p]);
         sender_idles = (p != QUIET_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = random_request(phase_len[p]);
            issue(r, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0 && pending_answers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/rmmt_pkg.sv
rtl/rmmt_node_store.sv
rtl/rmmt_seq.sv
rtl/range_max_min_tree_top.sv
rtl/rmmt_checker.sv
sim/range_max_min_tree_top_tb.sv
